/* design/jvdf_pkg.sv */
// Shared constants and types for the joint vector deadband filter.
package jvdf_pkg;

    // Default geometry of one joint vector.
    localparam int JOINT_COUNT_DEF = 7;
    localparam int ANGLE_WIDTH_DEF = 16;

    // Configuration register file.
    localparam int THR_W      = 16;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(8);

    // Register indexes (byte address = 4 * index).
    typedef enum logic [REG_IDX_W-1:0] {
        REG_THRESHOLD = 1'b0
    } t_reg_idx;

endpackage

/* design/jvdf_lane.sv */
// One joint lane: absolute difference between a new angle and the reference angle.
module jvdf_lane #(
    parameter int ANGLE_WIDTH = jvdf_pkg::ANGLE_WIDTH_DEF
) (
    input  logic signed [ANGLE_WIDTH-1:0] i_angle,
    input  logic signed [ANGLE_WIDTH-1:0] i_ref,
    output logic        [ANGLE_WIDTH-1:0] o_dist
);

    logic signed [ANGLE_WIDTH:0] w_diff;
    logic signed [ANGLE_WIDTH:0] w_abs;

    // One extra bit keeps the difference exact; its magnitude always fits the angle width.
    assign w_diff = {i_ref[ANGLE_WIDTH-1], i_ref} - {i_angle[ANGLE_WIDTH-1], i_angle};
    assign w_abs  = w_diff[ANGLE_WIDTH] ? -w_diff : w_diff;
    assign o_dist = w_abs[ANGLE_WIDTH-1:0];

endmodule

/* design/jvdf_merge.sv */
// Merging stage: maximum over all lane distances and comparison with the threshold.
module jvdf_merge #(
    parameter int JOINT_COUNT = jvdf_pkg::JOINT_COUNT_DEF,
    parameter int ANGLE_WIDTH = jvdf_pkg::ANGLE_WIDTH_DEF
) (
    input  logic [JOINT_COUNT-1:0][ANGLE_WIDTH-1:0] i_dist,
    input  logic [jvdf_pkg::THR_W-1:0]              i_threshold,
    output logic                                    o_over
);

    localparam int LEVELS = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 0;
    localparam int LEAVES = 1 << LEVELS;
    localparam int NODES  = 2 * LEAVES - 1;
    localparam int CMP_W  = (ANGLE_WIDTH > jvdf_pkg::THR_W) ? ANGLE_WIDTH : jvdf_pkg::THR_W;

    logic [NODES-1:0][ANGLE_WIDTH-1:0] w_node;

    // Leaves hold the lane distances; unused leaves are zero and never win.
    for (genvar g = 0; g < LEAVES; g++) begin : g_leaf
        if (g < JOINT_COUNT) begin : g_used
            assign w_node[LEAVES-1+g] = i_dist[g];
        end else begin : g_pad
            assign w_node[LEAVES-1+g] = '0;
        end
    end

    // Balanced tree of pairwise maxima; node 0 is the overall maximum.
    for (genvar n = 0; n < LEAVES - 1; n++) begin : g_tree
        assign w_node[n] = (w_node[2*n+1] > w_node[2*n+2]) ? w_node[2*n+1] : w_node[2*n+2];
    end

    assign o_over = CMP_W'(w_node[0]) > CMP_W'(i_threshold);

endmodule

/* design/joint_vector_deadband_filter.sv */
// Top level of the joint vector deadband filter: stream ports, reference, register file.
//
// Send-on-delta filter for joint position vectors. Each input transfer carries
// JOINT_COUNT signed angles (Q3.13 radians at the default width) and a start-of-plan
// flag in tuser. The block keeps the last emitted vector as its reference; one lane
// per joint forms the absolute difference to that reference, and a merging tree takes
// the largest one (the L-infinity distance). The vector is passed on, and becomes the
// new reference, only when that distance is strictly greater than the threshold
// register; a distance equal to the threshold is dropped. A vector with the start
// flag set, and the first vector after reset, always passes. Vectors that do not pass
// produce no output transfer. The whole decision (subtract, absolute value, maximum
// tree, compare) completes in the cycle in which the input transfer is taken, so the
// block sustains one vector per clock unless the master side stalls; the lanes and the
// maximum tree set the clock rate. The emitted vector appears on the master side in the
// cycle after its input transfer and stays there until taken; while it waits, the slave
// side still accepts a new vector whenever the output register will be free by the next
// edge. The threshold register sits at byte address 0 and resets to 8 (about 0.001 rad).
module joint_vector_deadband_filter #(
    parameter int JOINT_COUNT = jvdf_pkg::JOINT_COUNT_DEF,
    parameter int ANGLE_WIDTH = jvdf_pkg::ANGLE_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Slave stream side.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata fields from bit 0 up: joint_0, joint_1, ... joint_(JOINT_COUNT-1), zero pad.
    input  logic [((JOINT_COUNT*ANGLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // tuser fields from bit 0 up: start_plan.
    input  logic                                s_axis_tuser,
    // Master stream side.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata fields from bit 0 up: out_joint_0, ... out_joint_(JOINT_COUNT-1), zero pad.
    output logic [((JOINT_COUNT*ANGLE_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [jvdf_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [jvdf_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [jvdf_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int VEC_W  = JOINT_COUNT * ANGLE_WIDTH;
    localparam int DATA_W = ((VEC_W + 7) / 8) * 8;

    // Registers.
    logic [jvdf_pkg::THR_W-1:0]                 r_threshold;
    logic                                       r_have_ref;
    logic [JOINT_COUNT-1:0][ANGLE_WIDTH-1:0]    r_ref;
    logic                                       r_out_valid;
    logic [VEC_W-1:0]                           r_out_data;

    logic                                       n_out_valid;

    // Datapath and control.
    logic [JOINT_COUNT-1:0][ANGLE_WIDTH-1:0]    w_in_vec;
    logic [JOINT_COUNT-1:0][ANGLE_WIDTH-1:0]    w_dist;
    logic                                       w_over;
    logic                                       w_accept;
    logic                                       w_emit;
    logic                                       w_cfg_write;
    jvdf_pkg::t_reg_idx                         w_reg_idx;

    // ------------------------------------------------------------------
    // Configuration port. pready is tied high, so a write completes in the
    // access cycle.
    // ------------------------------------------------------------------
    assign pready      = 1'b1;
    assign w_reg_idx   = jvdf_pkg::t_reg_idx'(paddr[jvdf_pkg::APB_ADDR_W-1:2]);
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        if (w_reg_idx == jvdf_pkg::REG_THRESHOLD) begin
            prdata = jvdf_pkg::APB_DATA_W'(r_threshold);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= jvdf_pkg::THR_RESET;
        end else if (w_cfg_write && (w_reg_idx == jvdf_pkg::REG_THRESHOLD)) begin
            r_threshold <= pwdata[jvdf_pkg::THR_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Lanes and merging stage.
    // ------------------------------------------------------------------
    assign w_in_vec = s_axis_tdata[VEC_W-1:0];

    for (genvar g = 0; g < JOINT_COUNT; g++) begin : g_lane
        jvdf_lane #(
            .ANGLE_WIDTH (ANGLE_WIDTH)
        ) u_lane (
            .i_angle (w_in_vec[g]),
            .i_ref   (r_ref[g]),
            .o_dist  (w_dist[g])
        );
    end

    jvdf_merge #(
        .JOINT_COUNT (JOINT_COUNT),
        .ANGLE_WIDTH (ANGLE_WIDTH)
    ) u_merge (
        .i_dist      (w_dist),
        .i_threshold (r_threshold),
        .o_over      (w_over)
    );

    // ------------------------------------------------------------------
    // Stream control. The output register is free for a new vector when it
    // is empty or its content is taken at this same edge.
    // ------------------------------------------------------------------
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_emit        = s_axis_tuser || !r_have_ref || w_over;

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_accept && w_emit) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_have_ref  <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (w_accept && w_emit) begin
                r_have_ref <= 1'b1;
            end
        end
    end

    // The reference is only read once r_have_ref is set, so it needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_accept && w_emit) begin
            r_ref      <= w_in_vec;
            r_out_data <= w_in_vec;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = DATA_W'(r_out_data);

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // A start-of-plan vector always produces an output transfer.
    a_start_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && s_axis_tuser) |=> (m_axis_tvalid && r_have_ref))
        else $error("start-of-plan vector was not emitted");

    // An emitted vector reaches the output unchanged and becomes the reference.
    a_emit_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_emit) |=>
            (m_axis_tdata[VEC_W-1:0] == $past(s_axis_tdata[VEC_W-1:0]))
            && (r_ref == $past(w_in_vec)))
        else $error("emitted vector or reference differs from input");

    // A dropped vector never creates an output transfer.
    a_drop_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_emit && m_axis_tready) |=> !m_axis_tvalid)
        else $error("dropped vector produced an output transfer");

    // The reference stays put while no vector is emitted.
    a_ref_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_have_ref && !(w_accept && w_emit)) |=> $stable(r_ref))
        else $error("reference changed without an emitted vector");

endmodule

/* dv/tb_joint_vector_deadband_filter.sv */
// Testbench for the joint vector deadband filter: directed and random vectors checked against a predictor.
module tb_joint_vector_deadband_filter;

    localparam int JOINTS          = jvdf_pkg::JOINT_COUNT_DEF;
    localparam int AW              = jvdf_pkg::ANGLE_WIDTH_DEF;
    localparam int THR_W           = jvdf_pkg::THR_W;
    localparam int APB_DATA_W      = jvdf_pkg::APB_DATA_W;
    localparam int APB_ADDR_W      = jvdf_pkg::APB_ADDR_W;
    localparam int TDATA_W         = ((JOINTS * AW + 7) / 8) * 8;
    localparam int ANGLE_MAX       = 2 ** (AW - 1) - 1;
    localparam int ANGLE_MIN       = -(2 ** (AW - 1));
    localparam int THR_MAX         = 2 ** THR_W - 1;
    localparam int UNMAPPED_REG    = 1;      // register index with nothing behind it
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 155;
    localparam int SETTLE_CYCLES   = 6;      // output is registered in the cycle after input
    localparam int CYCLE_LIMIT     = 200000;
    localparam int START_PCT       = 4;      // share of random vectors that open a new plan

    typedef logic signed [AW-1:0] t_angle;
    typedef logic [TDATA_W-1:0]   t_tdata;

    typedef enum int {
        NEAR_REFERENCE,
        THRESHOLD_EDGE,
        FREE_RANDOM,
        RAIL_VALUES
    } t_stim_kind;

    // Tracks the reference vector and threshold, and holds the vectors that must pass.
    class emitted_vector_board;
        t_tdata           expected_vectors [$];
        t_tdata           last_emitted;
        bit               have_last;
        logic [THR_W-1:0] threshold;
        int               mismatches;

        function new();
            last_emitted = '0;
            have_last    = 1'b0;
            threshold    = jvdf_pkg::THR_RESET;
            mismatches   = 0;
        endfunction

        function void write_register(int idx, logic [APB_DATA_W-1:0] value);
            if (idx == int'(jvdf_pkg::REG_THRESHOLD))
                threshold = value[THR_W-1:0];
        endfunction

        function void note_accepted_vector(t_tdata data, bit start_plan);
            int largest;
            int diff;
            largest = 0;
            for (int j = 0; j < JOINTS; j++) begin
                diff = int'(t_angle'(last_emitted[j*AW +: AW]))
                     - int'(t_angle'(data[j*AW +: AW]));
                if (diff < 0)
                    diff = -diff;
                if (diff > largest)
                    largest = diff;
            end
            if (start_plan || !have_last || largest > int'(threshold)) begin
                last_emitted     = data;
                have_last        = 1'b1;
                expected_vectors = {expected_vectors, data};
            end
        endfunction

        function void check_emitted_vector(t_tdata actual);
            t_tdata want;
            if (expected_vectors.size() == 0) begin
                $display("%0t: output transfer with no vector pending, expected none, actual %h",
                         $time, actual);
                mismatches++;
                return;
            end
            want = expected_vectors.pop_front();
            for (int j = 0; j < JOINTS; j++) begin
                if (actual[j*AW +: AW] !== want[j*AW +: AW]) begin
                    $display("%0t: joint %0d expected %0d actual %0d", $time, j,
                             t_angle'(want[j*AW +: AW]), t_angle'(actual[j*AW +: AW]));
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    t_tdata                s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    t_tdata                m_axis_tdata;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    emitted_vector_board board;
    int sender_idle_pct;
    int receiver_stall_pct;
    int cycle_count = 0;

    joint_vector_deadband_filter DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("joint_vector_deadband_filter test failed");
            $finish;
        end
    end

    // Output side: check every transfer, and stall at the rate of the current phase.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                board.check_emitted_vector(m_axis_tdata);
            m_axis_tready <= (int'($urandom_range(99)) >= receiver_stall_pct);
        end
    end

    function automatic int clamp_angle(int val);
        if (val > ANGLE_MAX)
            return ANGLE_MAX;
        if (val < ANGLE_MIN)
            return ANGLE_MIN;
        return val;
    endfunction

    function automatic t_stim_kind pick_kind();
        int r;
        r = $urandom_range(99);
        if (r < 40)
            return NEAR_REFERENCE;
        if (r < 70)
            return THRESHOLD_EDGE;
        if (r < 90)
            return FREE_RANDOM;
        return RAIL_VALUES;
    endfunction

    // Builds a vector; near and edge kinds put distances from the reference near the threshold.
    function automatic t_tdata make_vector(t_stim_kind kind);
        t_tdata v;
        int     base;
        int     val;
        int     outer;
        int     inner;
        int     step;
        int     rail;
        int     edge_joint;
        outer      = (int'(board.threshold) < 30000) ? int'(board.threshold) + 2 : 30000;
        inner      = (int'(board.threshold) < 30000) ? int'(board.threshold) : 30000;
        edge_joint = $urandom_range(JOINTS - 1);
        for (int j = 0; j < JOINTS; j++) begin
            base = int'(t_angle'(board.last_emitted[j*AW +: AW]));
            case (kind)
                NEAR_REFERENCE: begin
                    val = base + int'($urandom_range(2 * outer)) - outer;
                end
                THRESHOLD_EDGE: begin
                    if (j == edge_joint) begin
                        // Exactly at the threshold or one past it, on whichever side fits.
                        step = int'(board.threshold) + int'($urandom_range(1));
                        val  = ($urandom_range(1) == 0) ? base + step : base - step;
                        if (val > ANGLE_MAX)
                            val = base - step;
                        else if (val < ANGLE_MIN)
                            val = base + step;
                    end else begin
                        val = base + int'($urandom_range(2 * inner)) - inner;
                    end
                end
                FREE_RANDOM: begin
                    val = int'(t_angle'($urandom));
                end
                default: begin
                    rail = $urandom_range(2);
                    val  = (rail == 0) ? ANGLE_MIN : (rail == 1) ? ANGLE_MAX : 0;
                end
            endcase
            v[j*AW +: AW] = AW'(clamp_angle(val));
        end
        return v;
    endfunction

    // Offers one vector, with a random idle gap first, and returns once it is taken.
    task automatic send_vector(input t_tdata data, input bit start_plan);
        while (int'($urandom_range(99)) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= start_plan;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        board.note_accepted_vector(data, start_plan);
    endtask

    // One register transfer: setup, access, then idle.
    task automatic apb_transfer(input bit is_write, input int idx,
                                input logic [APB_DATA_W-1:0] wdata,
                                output logic [APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= APB_ADDR_W'(idx * 4);
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        rdata = prdata;
        if (is_write)
            board.write_register(idx, wdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // A write to the unmapped index must leave the threshold alone; upper data bits are noise.
    task automatic load_threshold(input logic [THR_W-1:0] thr);
        logic [APB_DATA_W-1:0] readback;
        apb_transfer(1'b1, UNMAPPED_REG, $urandom, readback);
        apb_transfer(1'b1, jvdf_pkg::REG_THRESHOLD, {(APB_DATA_W-THR_W)'($urandom), thr},
                     readback);
        apb_transfer(1'b0, jvdf_pkg::REG_THRESHOLD, '0, readback);
        if (readback !== APB_DATA_W'(board.threshold)) begin
            $display("%0t: threshold readback expected %0d actual %0d",
                     $time, board.threshold, readback);
            board.mismatches++;
        end
    endtask

    task automatic wait_drained();
        while (board.expected_vectors.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [THR_W-1:0] phase_threshold(int p);
        case (p)
            0:       return '0;
            1:       return THR_W'(1);
            2:       return THR_W'(THR_MAX);
            3:       return THR_W'(THR_MAX - 1);
            4:       return jvdf_pkg::THR_RESET;
            5:       return THR_W'($urandom_range(2000, 2));
            6:       return THR_W'($urandom);
            default: return THR_W'(300);
        endcase
    endfunction

    initial begin
        t_tdata vec;
        board = new();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed vectors at the reset threshold of 8.
        vec = {JOINTS{t_angle'(ANGLE_MAX)}};
        send_vector(vec, 1'b0);                 // no reference yet, so it passes
        send_vector(vec, 1'b0);                 // zero distance
        vec[3*AW +: AW] = t_angle'(ANGLE_MAX - 8);
        send_vector(vec, 1'b0);                 // distance equal to the threshold is dropped
        vec[3*AW +: AW] = t_angle'(ANGLE_MAX - 9);
        send_vector(vec, 1'b0);                 // one past the threshold
        vec = {JOINTS{t_angle'(ANGLE_MIN)}};
        send_vector(vec, 1'b0);                 // full-scale distance, no wrap
        send_vector(vec, 1'b1);                 // start of plan passes at zero distance
        for (int j = 0; j < JOINTS; j++) begin
            vec[j*AW +: AW] = vec[j*AW +: AW] + AW'(9);
            send_vector(vec, 1'b0);             // each joint alone moves the vector
        end
        for (int j = 0; j < JOINTS; j++) begin
            vec[j*AW +: AW] = vec[j*AW +: AW] + AW'(8);
            send_vector(vec, 1'b0);             // each joint alone sits at the threshold
        end
        vec = {t_angle'(ANGLE_MAX), t_angle'(ANGLE_MIN), t_angle'(0), t_angle'(-1),
               t_angle'(1), t_angle'(12345), t_angle'(-12345)};
        send_vector(vec, 1'b0);
        vec = '0;
        send_vector(vec, 1'b1);
        s_axis_tvalid <= 1'b0;

        // Random phases, each with its own threshold and one of four idle patterns.
        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            load_threshold(phase_threshold(p));
            case (p % 4)
                0:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1:       begin sender_idle_pct = 47; receiver_stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  receiver_stall_pct = 47; end
                default: begin sender_idle_pct = 15; receiver_stall_pct = 15; end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_vector(make_vector(pick_kind()), int'($urandom_range(99)) < START_PCT);
            s_axis_tvalid <= 1'b0;
        end

        wait_drained();
        if (board.mismatches == 0 && board.expected_vectors.size() == 0)
            $display("joint_vector_deadband_filter test passed");
        else
            $display("joint_vector_deadband_filter test failed");
        $finish;
    end

endmodule
